### src/bti_pkg.sv
// shared types and constants for the bilinear table interpolation unit
package bti_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_WR_X  = 2'd0,
        REQ_WR_Y  = 2'd1,
        REQ_WR_G  = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [1:0] CFG_EXTRAP = 2'd0;
    localparam logic [1:0] CFG_XCNT   = 2'd1;
    localparam logic [1:0] CFG_YCNT   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    // largest quotient magnitude kept by the divider
    localparam logic [33:0] QUOT_CAP = 34'h2_0000_0000;

    // configuration as seen by the back end
    typedef struct packed {
        logic       ext;
        logic [4:0] xcnt;
        logic [4:0] ycnt;
    } cfg_t;

    // one classified item in the queue
    typedef struct packed {
        req_t               kind;
        logic [7:0]         index;
        logic signed [31:0] value;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } entry_t;

    // request to the linear step unit
    typedef struct packed {
        logic               start;
        logic               ext;
        logic signed [31:0] xl;
        logic signed [31:0] xr;
        logic signed [31:0] yl;
        logic signed [31:0] yr;
        logic signed [31:0] v;
    } lerp_req_t;

    // response of the linear step unit
    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
        logic               sat;
        logic               zero;
    } lerp_rsp_t;

    // linear step unit states
    typedef enum logic [3:0] {
        L_IDLE,
        L_PREP,
        L_ABS,
        L_MUL,
        L_DCHK,
        L_DIV,
        L_FIN,
        L_SAT
    } lerp_state_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_RD,
        S_LAST_CMP,
        S_STEP_RD,
        S_STEP_CMP,
        S_BASE,
        S_FETCH_RD,
        S_FETCH_CAP,
        S_L_START,
        S_L_WAIT,
        S_OUT
    } back_state_t;

endpackage

### src/bti_ram.sv
// generic single write port ram with registered read
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### src/bti_front.sv
// front end: accepts beats, drops out-of-range writes, queues the rest
module bti_front #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [103:0]    s_tdata,
    input  logic [1:0]      s_tuser,
    output bti_pkg::entry_t q_head,
    output logic            q_valid,
    input  logic            q_pop
);

    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;

    bti_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    bti_pkg::entry_t in_entry;
    logic            keep;
    logic            push;

    // unpack the beat
    always_comb
    begin
        in_entry.kind  = bti_pkg::req_t'(s_tuser);
        in_entry.index = s_tdata[7:0];
        in_entry.value = s_tdata[39:8];
        in_entry.qx    = s_tdata[71:40];
        in_entry.qy    = s_tdata[103:72];
    end

    // classify: writes past the table depth are dropped here
    always_comb
    begin
        unique case (in_entry.kind)
            bti_pkg::REQ_WR_X:  keep = {1'b0, in_entry.index} < 9'(MAX_X_POINTS);
            bti_pkg::REQ_WR_Y:  keep = {1'b0, in_entry.index} < 9'(MAX_Y_POINTS);
            bti_pkg::REQ_WR_G:  keep = 17'(in_entry.index) < 17'(GRID_DEPTH);
            bti_pkg::REQ_QUERY: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

### src/bti_lerp.sv
// linear step: yl + (yr - yl) * (v - xl) / (xr - xl) with saturation
module bti_lerp (
    input  logic               clk,
    input  logic               rst_n,
    input  bti_pkg::lerp_req_t req,
    output bti_pkg::lerp_rsp_t rsp
);

    bti_pkg::lerp_state_t state_reg, state_next;

    logic signed [31:0] xl_reg, xr_reg, yl_reg, yr_reg, v_reg;
    logic signed [32:0] dx_reg, dy_reg, t_reg;
    logic [31:0]        ma_reg, mb_reg, md_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        rem_reg;
    logic [64:0]        dsh_reg;
    logic [33:0]        q_reg;
    logic [5:0]         bit_reg;
    logic signed [34:0] qs_reg;

    logic signed [31:0] yr_c, yl_c;
    logic               cap_hit;
    logic               div_ge;
    logic [33:0]        q_capped;
    logic signed [35:0] sum;

    // clamp to end values when extrapolation is off
    always_comb
    begin
        yr_c = (!req.ext && (req.v < req.xl)) ? req.yl : req.yr;
        yl_c = (!req.ext && (req.v > req.xr)) ? yr_c : req.yl;
    end

    assign cap_hit  = {2'b00, prod_reg} >= {md_reg, 34'b0};
    assign div_ge   = {1'b0, rem_reg} >= dsh_reg;
    assign q_capped = (q_reg > bti_pkg::QUOT_CAP) ? bti_pkg::QUOT_CAP : q_reg;
    assign sum      = 36'(yl_reg) + 36'(qs_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bti_pkg::L_IDLE: if (req.start) state_next = bti_pkg::L_PREP;
            bti_pkg::L_PREP: state_next = bti_pkg::L_ABS;
            bti_pkg::L_ABS:  state_next = (dx_reg == 33'sd0) ? bti_pkg::L_SAT : bti_pkg::L_MUL;
            bti_pkg::L_MUL:  state_next = bti_pkg::L_DCHK;
            bti_pkg::L_DCHK: state_next = cap_hit ? bti_pkg::L_FIN : bti_pkg::L_DIV;
            bti_pkg::L_DIV:  if (bit_reg == 6'd0) state_next = bti_pkg::L_FIN;
            bti_pkg::L_FIN:  state_next = bti_pkg::L_SAT;
            bti_pkg::L_SAT:  state_next = bti_pkg::L_IDLE;
            default:         state_next = bti_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bti_pkg::L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bti_pkg::L_IDLE:
            begin
                xl_reg   <= req.xl;
                xr_reg   <= req.xr;
                yl_reg   <= yl_c;
                yr_reg   <= yr_c;
                v_reg    <= req.v;
                zero_reg <= 1'b0;
            end
            bti_pkg::L_PREP:
            begin
                dx_reg <= 33'(xr_reg) - 33'(xl_reg);
                dy_reg <= 33'(yr_reg) - 33'(yl_reg);
                t_reg  <= 33'(v_reg) - 33'(xl_reg);
            end
            bti_pkg::L_ABS:
            begin
                // magnitudes stay below 2^32
                ma_reg  <= dy_reg[32] ? 32'(-dy_reg) : dy_reg[31:0];
                mb_reg  <= t_reg[32] ? 32'(-t_reg) : t_reg[31:0];
                md_reg  <= dx_reg[32] ? 32'(-dx_reg) : dx_reg[31:0];
                neg_reg <= dy_reg[32] ^ dx_reg[32] ^ t_reg[32];
                if (dx_reg == 33'sd0)
                begin
                    zero_reg <= 1'b1;
                    qs_reg   <= 35'sd0;
                end
            end
            bti_pkg::L_MUL:
            begin
                prod_reg <= ma_reg * mb_reg;
            end
            bti_pkg::L_DCHK:
            begin
                rem_reg <= prod_reg;
                dsh_reg <= {md_reg, 33'b0};
                bit_reg <= 6'd33;
                q_reg   <= cap_hit ? '1 : '0;
            end
            bti_pkg::L_DIV:
            begin
                // one restoring quotient bit per cycle
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg[63:0];
                end
                q_reg   <= {q_reg[32:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
                bit_reg <= bit_reg - 6'd1;
            end
            bti_pkg::L_FIN:
            begin
                qs_reg <= neg_reg ? -$signed({1'b0, q_capped}) : $signed({1'b0, q_capped});
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rsp.done  = (state_reg == bti_pkg::L_SAT);
        rsp.zero  = zero_reg;
        rsp.sat   = 1'b0;
        rsp.value = sum[31:0];
        if (sum > 36'sh0_7FFF_FFFF)
        begin
            rsp.sat   = 1'b1;
            rsp.value = 32'sh7FFF_FFFF;
        end
        else if (sum < -36'sh0_8000_0000)
        begin
            rsp.sat   = 1'b1;
            rsp.value = -32'sh8000_0000;
        end
    end

endmodule

### src/bti_back.sv
// back end: table writes, segment search, fetch and three linear steps
module bti_back #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bti_pkg::cfg_t   cfg,
    input  bti_pkg::entry_t q_head,
    input  logic            q_valid,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic [1:0]      m_tuser
);

    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int XAW = $clog2(MAX_X_POINTS);
    localparam int YAW = $clog2(MAX_Y_POINTS);
    localparam int GAW = $clog2(GRID_DEPTH);
    localparam int SAW = (XAW > YAW) ? XAW : YAW;
    localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int CW = $clog2(MAXP + 1);

    bti_pkg::back_state_t state_reg, state_next;

    logic signed [31:0] qx_reg, qy_reg;
    logic               axis_reg;
    logic [SAW-1:0]     seg_reg;
    logic [XAW-1:0]     xa_reg;
    logic [YAW-1:0]     ya_reg;
    logic [GAW-1:0]     g0_reg;
    logic [2:0]         f_reg;
    logic signed [31:0] val_reg [8];
    logic [1:0]         lp_reg;
    logic signed [31:0] v1_reg, v2_reg, res_reg;
    logic               sat_reg, zero_reg;

    logic [CW-1:0]      nx, ny, n_cur, srch_addr;
    logic signed [31:0] v_cur, rd_cur;
    logic               last_hit, step_more, step_hit, axis_fin;
    logic [SAW-1:0]     fin_seg;
    logic [GAW-1:0]     g_addr;

    logic               x_we, y_we, g_we;
    logic [XAW-1:0]     x_raddr;
    logic [YAW-1:0]     y_raddr;
    logic [GAW-1:0]     g_raddr;
    logic [31:0]        x_rdata, y_rdata, g_rdata;

    bti_pkg::lerp_req_t lreq;
    bti_pkg::lerp_rsp_t lrsp;

    // point counts held to their legal range
    always_comb
    begin
        if (cfg.xcnt < 5'd2)
            nx = CW'(2);
        else if (32'(cfg.xcnt) > MAX_X_POINTS)
            nx = CW'(MAX_X_POINTS);
        else
            nx = CW'(cfg.xcnt);
        if (cfg.ycnt < 5'd2)
            ny = CW'(2);
        else if (32'(cfg.ycnt) > MAX_Y_POINTS)
            ny = CW'(MAX_Y_POINTS);
        else
            ny = CW'(cfg.ycnt);
    end

    // search helpers for the current axis
    always_comb
    begin
        n_cur     = axis_reg ? ny : nx;
        v_cur     = axis_reg ? qy_reg : qx_reg;
        rd_cur    = axis_reg ? $signed(y_rdata) : $signed(x_rdata);
        last_hit  = v_cur >= rd_cur;
        step_hit  = v_cur > rd_cur;
        step_more = (CW'(seg_reg) + CW'(1)) < (n_cur - CW'(1));
        srch_addr = (state_reg == bti_pkg::S_LAST_RD) ? (n_cur - CW'(2))
                                                      : (CW'(seg_reg) + CW'(1));
        fin_seg   = (state_reg == bti_pkg::S_LAST_CMP) ? SAW'(n_cur - CW'(2)) : seg_reg;
        axis_fin  = ((state_reg == bti_pkg::S_LAST_CMP) && last_hit)
                 || ((state_reg == bti_pkg::S_STEP_RD) && !step_more)
                 || ((state_reg == bti_pkg::S_STEP_CMP) && !step_hit);
    end

    // grid address of the fetch step
    always_comb
    begin
        case (f_reg[1:0])
            2'd0:    g_addr = g0_reg;
            2'd1:    g_addr = g0_reg + GAW'(1);
            2'd2:    g_addr = g0_reg + GAW'(ny);
            default: g_addr = g0_reg + GAW'(ny) + GAW'(1);
        endcase
    end

    assign q_pop = (state_reg == bti_pkg::S_IDLE) && q_valid;

    // ram ports
    always_comb
    begin
        x_we    = q_pop && (q_head.kind == bti_pkg::REQ_WR_X);
        y_we    = q_pop && (q_head.kind == bti_pkg::REQ_WR_Y);
        g_we    = q_pop && (q_head.kind == bti_pkg::REQ_WR_G);
        x_raddr = XAW'(srch_addr);
        y_raddr = YAW'(srch_addr);
        g_raddr = g_addr;
        if (state_reg == bti_pkg::S_FETCH_RD)
        begin
            x_raddr = xa_reg + XAW'(f_reg[0]);
            y_raddr = ya_reg + YAW'(f_reg[0]);
        end
    end

    bti_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_xram (
        .clk(clk), .we(x_we), .waddr(XAW'(q_head.index)), .wdata(q_head.value),
        .raddr(x_raddr), .rdata(x_rdata)
    );

    bti_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_yram (
        .clk(clk), .we(y_we), .waddr(YAW'(q_head.index)), .wdata(q_head.value),
        .raddr(y_raddr), .rdata(y_rdata)
    );

    bti_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_gram (
        .clk(clk), .we(g_we), .waddr(GAW'(q_head.index)), .wdata(q_head.value),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    // operands of the shared linear step unit
    always_comb
    begin
        lreq.start = (state_reg == bti_pkg::S_L_START);
        lreq.ext   = cfg.ext;
        lreq.xl    = val_reg[2];
        lreq.xr    = val_reg[3];
        lreq.yl    = val_reg[4];
        lreq.yr    = val_reg[5];
        lreq.v     = qy_reg;
        case (lp_reg)
            2'd0:
            begin
            end
            2'd1:
            begin
                lreq.yl = val_reg[6];
                lreq.yr = val_reg[7];
            end
            default:
            begin
                lreq.xl = val_reg[0];
                lreq.xr = val_reg[1];
                lreq.yl = v1_reg;
                lreq.yr = v2_reg;
                lreq.v  = qx_reg;
            end
        endcase
    end

    bti_lerp u_lerp (
        .clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bti_pkg::S_IDLE:
                if (q_valid && (q_head.kind == bti_pkg::REQ_QUERY))
                    state_next = bti_pkg::S_LAST_RD;
            bti_pkg::S_LAST_RD:
                state_next = bti_pkg::S_LAST_CMP;
            bti_pkg::S_LAST_CMP, bti_pkg::S_STEP_RD, bti_pkg::S_STEP_CMP:
            begin
                if (axis_fin)
                    state_next = axis_reg ? bti_pkg::S_BASE : bti_pkg::S_LAST_RD;
                else if (state_reg == bti_pkg::S_STEP_RD)
                    state_next = bti_pkg::S_STEP_CMP;
                else
                    state_next = bti_pkg::S_STEP_RD;
            end
            bti_pkg::S_BASE:
                state_next = bti_pkg::S_FETCH_RD;
            bti_pkg::S_FETCH_RD:
                state_next = bti_pkg::S_FETCH_CAP;
            bti_pkg::S_FETCH_CAP:
                state_next = (f_reg == 3'd7) ? bti_pkg::S_L_START : bti_pkg::S_FETCH_RD;
            bti_pkg::S_L_START:
                state_next = bti_pkg::S_L_WAIT;
            bti_pkg::S_L_WAIT:
                if (lrsp.done)
                    state_next = (lp_reg == 2'd2) ? bti_pkg::S_OUT : bti_pkg::S_L_START;
            bti_pkg::S_OUT:
                if (m_tready)
                    state_next = bti_pkg::S_IDLE;
            default:
                state_next = bti_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bti_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bti_pkg::S_IDLE:
            begin
                qx_reg   <= q_head.qx;
                qy_reg   <= q_head.qy;
                axis_reg <= 1'b0;
                sat_reg  <= 1'b0;
                zero_reg <= 1'b0;
                lp_reg   <= 2'd0;
                f_reg    <= 3'd0;
            end
            bti_pkg::S_LAST_CMP, bti_pkg::S_STEP_RD, bti_pkg::S_STEP_CMP:
            begin
                if (axis_fin)
                begin
                    if (axis_reg)
                        ya_reg <= YAW'(fin_seg);
                    else
                        xa_reg <= XAW'(fin_seg);
                    axis_reg <= 1'b1;
                end
                else if (state_reg == bti_pkg::S_LAST_CMP)
                    seg_reg <= '0;
                else if (state_reg == bti_pkg::S_STEP_CMP)
                    seg_reg <= seg_reg + SAW'(1);
            end
            bti_pkg::S_BASE:
            begin
                g0_reg <= GAW'(GAW'(xa_reg) * GAW'(ny)) + GAW'(ya_reg);
            end
            bti_pkg::S_FETCH_CAP:
            begin
                if (f_reg < 3'd2)
                    val_reg[f_reg] <= $signed(x_rdata);
                else if (f_reg < 3'd4)
                    val_reg[f_reg] <= $signed(y_rdata);
                else
                    val_reg[f_reg] <= $signed(g_rdata);
                f_reg <= f_reg + 3'd1;
            end
            bti_pkg::S_L_WAIT:
            begin
                if (lrsp.done)
                begin
                    case (lp_reg)
                        2'd0:    v1_reg  <= lrsp.value;
                        2'd1:    v2_reg  <= lrsp.value;
                        default: res_reg <= lrsp.value;
                    endcase
                    sat_reg  <= sat_reg | lrsp.sat;
                    zero_reg <= zero_reg | lrsp.zero;
                    lp_reg   <= lp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result beat
    always_comb
    begin
        m_tvalid = (state_reg == bti_pkg::S_OUT);
        m_tdata  = res_reg;
        if (zero_reg)
            m_tuser = bti_pkg::STAT_ZERO;
        else if (sat_reg)
            m_tuser = bti_pkg::STAT_SAT;
        else
            m_tuser = bti_pkg::STAT_OK;
    end

endmodule

### src/bilinear_table_interpolation_unit.sv
// A table write is stored in its ram as the back end pops it; a query runs the x and y
// segment search, the fetch of eight table values and three linear steps.
// Throughput is one item at a time in the back end, set by the shared linear
// step unit (one quotient bit per cycle over 34 bits).
// A two-beat queue keeps taking beats while a result waits, until it is full.
// Reset: asynchronous active low; clears control, counts to 16, extrapolation off.
module bilinear_table_interpolation_unit #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // table_index, table_value, query_x, query_y
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // interpolated_value
    output logic [1:0]   m_tuser    // status
);

    bti_pkg::cfg_t   cfg_reg;
    bti_pkg::entry_t q_head;
    logic            q_valid;
    logic            q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext  <= 1'b0;
            cfg_reg.xcnt <= 5'd16;
            cfg_reg.ycnt <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bti_pkg::CFG_EXTRAP: cfg_reg.ext  <= cfg_data[0];
                bti_pkg::CFG_XCNT:   cfg_reg.xcnt <= cfg_data;
                bti_pkg::CFG_YCNT:   cfg_reg.ycnt <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bti_front #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_head(q_head), .q_valid(q_valid), .q_pop(q_pop)
    );

    bti_back #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_head(q_head), .q_valid(q_valid), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // never pop an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // back end holds off the queue while a result waits
    a_hold_queue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !q_pop)
        else $error("queue popped while result pending");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == bti_pkg::STAT_OK || m_tuser == bti_pkg::STAT_SAT
                      || m_tuser == bti_pkg::STAT_ZERO))
        else $error("undefined status code");

endmodule
